// File: src/fsc_pkg.sv
// Package for the file signature classifier: constants, signature tables, shared types.
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

    // Default number of start positions scanned for the Office marker
    localparam int SCAN_STARTS_DEF = 512;

    // Office marker length and depth of the recent-byte history
    localparam int MARK_LEN = 11;
    localparam int RECENT_N = MARK_LEN - 1;

    // Prefix signature lengths
    localparam int LEN_PDF  = 7;
    localparam int LEN_7Z   = 5;
    localparam int LEN_VMDK = 8;
    localparam int LEN_PNG  = 8;

    // Prefix signatures, element 0 is the byte at offset 0 (unused tail is zero)
    localparam logic [7:0][7:0] SIG_PDF  =
        {8'h00, 8'h2E, 8'h31, 8'h2D, 8'h46, 8'h44, 8'h50, 8'h25};
    localparam logic [7:0][7:0] SIG_7Z   =
        {8'h00, 8'h00, 8'h00, 8'h27, 8'hAF, 8'hBC, 8'h7A, 8'h37};
    localparam logic [7:0][7:0] SIG_VMDK =
        {8'h00, 8'h00, 8'h00, 8'h01, 8'h56, 8'h4D, 8'h44, 8'h4B};
    localparam logic [7:0][7:0] SIG_PNG  =
        {8'h0A, 8'h1A, 8'h0A, 8'h0D, 8'h47, 8'h4E, 8'h50, 8'h89};

    // Office marker "_Types].xml", element 0 is the first character
    localparam logic [MARK_LEN-1:0][7:0] SIG_OFFICE =
        {8'h6C, 8'h6D, 8'h78, 8'h2E, 8'h5D, 8'h73, 8'h65, 8'h70, 8'h79, 8'h54, 8'h5F};

    // Bit positions in the alive vector
    localparam int AL_PDF  = 0;
    localparam int AL_7Z   = 1;
    localparam int AL_VMDK = 2;
    localparam int AL_PNG  = 3;

    // Bit positions in the enable mask
    localparam int EN_PDF    = 0;
    localparam int EN_OFFICE = 1;
    localparam int EN_7Z     = 2;
    localparam int EN_VMDK   = 3;
    localparam int EN_PNG    = 4;

    localparam logic [4:0] ENABLE_RESET = 5'd31;

    // Reported type codes
    typedef enum logic [2:0] {
        FT_NONE   = 3'd0,
        FT_PDF    = 3'd1,
        FT_OFFICE = 3'd2,
        FT_7Z     = 3'd3,
        FT_VMDK   = 3'd4,
        FT_PNG    = 3'd5
    } t_file_type;

    // Result handed from the scan stage to the output register
    typedef struct packed {
        logic       valid;
        t_file_type file_type;
    } t_scan_res;

endpackage

`default_nettype wire

// File: src/fsc_if.sv
// Channel interfaces of the file signature classifier: byte input, type output, config write.
`timescale 1ns / 1ps
`default_nettype none

interface fsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface fsc_type_if;
    logic       valid;
    logic       ready;
    logic [2:0] file_type;

    modport source (output valid, output file_type, input ready);
    modport sink   (input valid, input file_type, output ready);
endinterface

interface fsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] enable_mask;

    modport source (output valid, output enable_mask, input ready);
    modport sink   (input valid, input enable_mask, output ready);
endinterface

`default_nettype wire

// File: src/fsc_scan.sv
// Scan stage: per-buffer match state, signature checks and type priority.
`timescale 1ns / 1ps
`default_nettype none

module fsc_scan
    import fsc_pkg::*;
#(
    parameter int SCAN_STARTS = SCAN_STARTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_is_last,
    input  wire logic [4:0] i_enable_mask,
    output t_scan_res       o_res
);

    // Position saturates one past the last byte that can end a marker
    localparam int POS_LIMIT = SCAN_STARTS + MARK_LEN - 1;
    localparam int POS_W     = $clog2(POS_LIMIT + 1);

    logic [POS_W-1:0]         r_pos, n_pos;
    logic [3:0]               r_alive, n_alive;
    logic [RECENT_N-1:0][7:0] r_recent, n_recent;
    logic                     r_office, n_office;

    logic       in_window;
    logic       office_hit;
    t_file_type code;

    // Update of the match state for the byte at hand
    always_comb begin
        in_window  = (r_pos < POS_W'(POS_LIMIT));
        office_hit = (r_pos >= POS_W'(RECENT_N)) &&
                     (r_recent == SIG_OFFICE[RECENT_N-1:0]) &&
                     (i_data_byte == SIG_OFFICE[MARK_LEN-1]);

        n_pos    = r_pos;
        n_alive  = r_alive;
        n_recent = r_recent;
        n_office = r_office;

        if (in_window) begin
            if (r_pos < POS_W'(LEN_PDF) && SIG_PDF[r_pos[2:0]] != i_data_byte) begin
                n_alive[AL_PDF] = 1'b0;
            end
            if (r_pos < POS_W'(LEN_7Z) && SIG_7Z[r_pos[2:0]] != i_data_byte) begin
                n_alive[AL_7Z] = 1'b0;
            end
            if (r_pos < POS_W'(LEN_VMDK) && SIG_VMDK[r_pos[2:0]] != i_data_byte) begin
                n_alive[AL_VMDK] = 1'b0;
            end
            if (r_pos < POS_W'(LEN_PNG) && SIG_PNG[r_pos[2:0]] != i_data_byte) begin
                n_alive[AL_PNG] = 1'b0;
            end
            if (office_hit) begin
                n_office = 1'b1;
            end
            n_recent = {i_data_byte, r_recent[RECENT_N-1:1]};
            n_pos    = r_pos + POS_W'(1);
        end
    end

    // Priority: pdf, office, 7z, vmdk, png, from the state after this byte
    always_comb begin
        if (i_enable_mask[EN_PDF] && n_alive[AL_PDF] && n_pos >= POS_W'(LEN_PDF)) begin
            code = FT_PDF;
        end else if (i_enable_mask[EN_OFFICE] && n_office) begin
            code = FT_OFFICE;
        end else if (i_enable_mask[EN_7Z] && n_alive[AL_7Z] && n_pos >= POS_W'(LEN_7Z)) begin
            code = FT_7Z;
        end else if (i_enable_mask[EN_VMDK] && n_alive[AL_VMDK] &&
                     n_pos >= POS_W'(LEN_VMDK)) begin
            code = FT_VMDK;
        end else if (i_enable_mask[EN_PNG] && n_alive[AL_PNG] &&
                     n_pos >= POS_W'(LEN_PNG)) begin
            code = FT_PNG;
        end else begin
            code = FT_NONE;
        end
    end

    assign o_res.valid     = i_accept && i_is_last;
    assign o_res.file_type = code;

    // State registers; the last byte of a buffer returns them to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_alive  <= 4'hF;
            r_recent <= '0;
            r_office <= 1'b0;
        end else if (i_accept) begin
            if (i_is_last) begin
                r_pos    <= '0;
                r_alive  <= 4'hF;
                r_recent <= '0;
                r_office <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_alive  <= n_alive;
                r_recent <= n_recent;
                r_office <= n_office;
            end
        end
    end

    // Position never runs past its saturation point
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(POS_LIMIT))
        else $error("fsc_scan: byte position beyond limit");

    // End of buffer clears the state
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_is_last |=> r_pos == '0 && !r_office && r_alive == 4'hF)
        else $error("fsc_scan: state not cleared after last byte");

    // A byte inside the window advances the position by one
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_is_last && r_pos < POS_W'(POS_LIMIT)
        |=> r_pos == $past(r_pos) + POS_W'(1))
        else $error("fsc_scan: byte position did not advance");

endmodule

`default_nettype wire

// File: src/fsc_out_reg.sv
// Output register holding one result type code until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module fsc_out_reg
    import fsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_scan_res  i_res,
    input  wire logic       i_ready,
    output logic            o_valid,
    output logic [2:0]      o_file_type,
    output logic            o_room
);

    logic       r_valid;
    logic [2:0] r_type;

    // Free when empty or when the held result leaves in this cycle
    assign o_room      = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_file_type = r_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_type <= i_res.file_type;
        end
    end

    // A new result never lands on a stalled one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |-> !i_res.valid)
        else $error("fsc_out_reg: result overwritten while stalled");

    // A stalled result is held unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_type))
        else $error("fsc_out_reg: stalled result changed");

    // A taken result with nothing behind it empties the register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_ready && !i_res.valid |=> !r_valid)
        else $error("fsc_out_reg: result delivered twice");

endmodule

`default_nettype wire

// File: src/file_signature_classifier_core.sv
// Top level of the file signature classifier: channels, enable register, scan and output stages.
// The type code is valid in the cycle after the transaction carrying the last byte.
// Throughput: one byte per cycle; the byte input stalls only while a finished
//   result sits in the output register and the sink is not ready.
// The scan stage updates its match state and decides the type code in the same cycle.
// Reset (synchronous, active low) clears buffer state and output valid flag, mask to all ones.
`timescale 1ns / 1ps
`default_nettype none

module file_signature_classifier_core
    import fsc_pkg::*;
#(
    parameter int SCAN_STARTS = SCAN_STARTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fsc_byte_if.sink   i_byte,
    fsc_cfg_if.sink    i_cfg,
    fsc_type_if.source o_type
);

    logic [4:0] r_enable_mask;
    logic       room;
    logic       accept;
    t_scan_res  scan_res;

    // Byte transaction
    assign i_byte.ready = room;
    assign accept       = i_byte.valid && room;

    // Enable mask register, written at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= ENABLE_RESET;
        end else if (i_cfg.valid) begin
            r_enable_mask <= i_cfg.enable_mask;
        end
    end

    fsc_scan #(
        .SCAN_STARTS (SCAN_STARTS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_byte.data_byte),
        .i_is_last     (i_byte.is_last),
        .i_enable_mask (r_enable_mask),
        .o_res         (scan_res)
    );

    fsc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (scan_res),
        .i_ready     (o_type.ready),
        .o_valid     (o_type.valid),
        .o_file_type (o_type.file_type),
        .o_room      (room)
    );

endmodule

`default_nettype wire
